// ===== hdl/lrwm_pkg.sv =====
// Shared types and constants for the loop rate window meter.
// Used by lrwm_divider and loop_rate_window_meter_core; no dependencies.
`default_nettype none

package lrwm_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_CLOCK_HZ        = 2'd0;
    localparam logic [1:0] CFG_WINDOW_LENGTH   = 2'd1;
    localparam logic [1:0] CFG_CYCLES_PER_US   = 2'd2;

    // Configuration reset values
    localparam logic [29:0] CLOCK_HZ_RESET      = 30'd125000000;
    localparam logic [31:0] WINDOW_LENGTH_RESET = 32'd125000000;
    localparam logic [9:0]  CYCLES_PER_US_RESET = 10'd125;

    // Item kinds
    localparam logic KIND_ITERATION = 1'b0;
    localparam logic KIND_RESTART   = 1'b1;

    // Divider step counts: full 32-bit rate quotient, 16-bit microsecond quotient
    localparam logic [5:0] STEPS_RATE = 6'd32;
    localparam logic [5:0] STEPS_US   = 6'd16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_CHECK,
        ST_MUL,
        ST_RATE_GO,
        ST_RATE_WAIT,
        ST_MIN_GO,
        ST_MIN_WAIT,
        ST_MAX_GO,
        ST_MAX_WAIT,
        ST_FINISH
    } state_t;

    // Request to the shared divider: (num_hi:num_lo) / den, num_hi < den unless saturating
    typedef struct packed {
        logic        start;
        logic [5:0]  steps;
        logic [31:0] num_hi;
        logic [31:0] num_lo;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/lrwm_divider.sv =====
// Shared restoring divider, one quotient bit per cycle, saturating to all ones.
// Depends on lrwm_pkg for the request and response structs.
`default_nettype none

module lrwm_divider (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire lrwm_pkg::div_req_t req,
    output lrwm_pkg::div_rsp_t      rsp
);

    logic [31:0] rem_reg;
    logic [31:0] low_reg;
    logic [31:0] den_reg;
    logic [31:0] quo_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [32:0] trial;
    logic [32:0] diff;
    logic        fits;

    assign trial = {rem_reg, low_reg[31]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = !diff[32];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (busy_reg) begin
                rem_reg <= fits ? diff[31:0] : trial[31:0];
                low_reg <= {low_reg[30:0], 1'b0};
                quo_reg <= {quo_reg[30:0], fits};
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end else if (req.start) begin
                // Upper half at or above the divisor: quotient overflows, saturate
                if (req.num_hi >= req.den) begin
                    quo_reg  <= '1;
                    done_reg <= 1'b1;
                end else begin
                    rem_reg  <= req.num_hi;
                    low_reg  <= req.num_lo;
                    den_reg  <= req.den;
                    quo_reg  <= '0;
                    cnt_reg  <= req.steps;
                    busy_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

// ===== hdl/loop_rate_window_meter_core.sv =====
// Loop rate window meter: counts loop passes per window, reports rate and intervals.
// Depends on lrwm_pkg and lrwm_divider.
//
// Input channel (s_valid/s_ready): s_kind 0 is a loop pass at s_timestamp,
// s_kind 1 restarts the window at s_timestamp and never gives a result.
// Output channel (m_valid/m_ready): one item when a window closes, carrying
// rate in hertz and the shortest and longest pass interval in microseconds.
// Configuration: cfg_wr_en writes cfg_wdata into the register at cfg_index
// (0 clock_hz, 1 window_length_cycles, 2 cycles_per_microsecond); the user must
// write only while idle, as the block itself does not enforce it.
// One item is worked on at a time; s_ready is high only when idle.
// A restart is taken in idle; a pass that closes no window runs update and check.
// A pass that closes a window also runs one 32x30 multiply, then
// the shared bit-serial divider runs 32 steps for the rate and 16 steps for
// each interval conversion.
// The result sits in an output register; a stalled receiver holds the block
// only when a second result is ready before the first one is taken.
// Reset restores the configuration defaults, opens an empty window at time 0
// and drops any pending result.
`default_nettype none

module loop_rate_window_meter_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output      logic        s_ready,
    input  wire logic        s_kind,
    input  wire logic [31:0] s_timestamp,

    output      logic        m_valid,
    input  wire logic        m_ready,
    output      logic [31:0] m_rate_hz,
    output      logic [15:0] m_min_interval_us,
    output      logic [15:0] m_max_interval_us,

    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);

    lrwm_pkg::state_t state_reg, state_next;

    logic [29:0] clock_hz_reg;
    logic [31:0] window_length_reg;
    logic [9:0]  cycles_per_us_reg;

    logic [31:0] window_start_reg;
    logic [31:0] previous_time_reg;
    logic [31:0] pass_count_reg;
    logic [31:0] shortest_reg;
    logic [31:0] longest_reg;
    logic        seen_reg;

    logic [31:0] now_reg;
    logic [31:0] span_reg;
    logic [61:0] product_reg;
    logic [31:0] rate_q_reg;
    logic [15:0] min_q_reg;
    logic [15:0] max_q_reg;

    logic        m_valid_reg;
    logic [31:0] m_rate_reg;
    logic [15:0] m_min_reg;
    logic [15:0] m_max_reg;

    logic        in_fire;
    logic        slot_free;
    logic [31:0] elapsed;

    lrwm_pkg::div_req_t div_req;
    lrwm_pkg::div_rsp_t div_rsp;

    assign in_fire   = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;
    assign elapsed   = now_reg - previous_time_reg;

    lrwm_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lrwm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        s_ready        = 1'b0;
        div_req.start  = 1'b0;
        div_req.steps  = lrwm_pkg::STEPS_US;
        div_req.num_hi = {16'd0, longest_reg[31:16]};
        div_req.num_lo = {longest_reg[15:0], 16'd0};
        div_req.den    = {22'd0, cycles_per_us_reg};
        case (state_reg)
            lrwm_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (in_fire && s_kind == lrwm_pkg::KIND_ITERATION) begin
                    state_next = lrwm_pkg::ST_UPDATE;
                end
            end
            lrwm_pkg::ST_UPDATE: begin
                state_next = lrwm_pkg::ST_CHECK;
            end
            lrwm_pkg::ST_CHECK: begin
                state_next = (span_reg < window_length_reg) ? lrwm_pkg::ST_IDLE
                                                            : lrwm_pkg::ST_MUL;
            end
            lrwm_pkg::ST_MUL: begin
                state_next = lrwm_pkg::ST_RATE_GO;
            end
            lrwm_pkg::ST_RATE_GO: begin
                div_req.start  = 1'b1;
                div_req.steps  = lrwm_pkg::STEPS_RATE;
                div_req.num_hi = {2'd0, product_reg[61:32]};
                div_req.num_lo = product_reg[31:0];
                div_req.den    = span_reg;
                state_next     = lrwm_pkg::ST_RATE_WAIT;
            end
            lrwm_pkg::ST_RATE_WAIT: begin
                if (div_rsp.done) begin
                    state_next = lrwm_pkg::ST_MIN_GO;
                end
            end
            lrwm_pkg::ST_MIN_GO: begin
                div_req.start  = 1'b1;
                div_req.num_hi = {16'd0, shortest_reg[31:16]};
                div_req.num_lo = {shortest_reg[15:0], 16'd0};
                state_next     = lrwm_pkg::ST_MIN_WAIT;
            end
            lrwm_pkg::ST_MIN_WAIT: begin
                if (div_rsp.done) begin
                    state_next = lrwm_pkg::ST_MAX_GO;
                end
            end
            lrwm_pkg::ST_MAX_GO: begin
                div_req.start = 1'b1;
                state_next    = lrwm_pkg::ST_MAX_WAIT;
            end
            lrwm_pkg::ST_MAX_WAIT: begin
                if (div_rsp.done) begin
                    state_next = lrwm_pkg::ST_FINISH;
                end
            end
            lrwm_pkg::ST_FINISH: begin
                if (slot_free) begin
                    state_next = lrwm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lrwm_pkg::ST_IDLE;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_hz_reg      <= lrwm_pkg::CLOCK_HZ_RESET;
            window_length_reg <= lrwm_pkg::WINDOW_LENGTH_RESET;
            cycles_per_us_reg <= lrwm_pkg::CYCLES_PER_US_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lrwm_pkg::CFG_CLOCK_HZ:      clock_hz_reg      <= cfg_wdata[29:0];
                lrwm_pkg::CFG_WINDOW_LENGTH: window_length_reg <= cfg_wdata;
                lrwm_pkg::CFG_CYCLES_PER_US: cycles_per_us_reg <= cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    // Window state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_start_reg  <= '0;
            previous_time_reg <= '0;
            pass_count_reg    <= '0;
            shortest_reg      <= '1;
            longest_reg       <= '0;
            seen_reg          <= 1'b0;
        end else begin
            case (state_reg)
                lrwm_pkg::ST_IDLE: begin
                    if (in_fire && s_kind == lrwm_pkg::KIND_RESTART) begin
                        window_start_reg  <= s_timestamp;
                        previous_time_reg <= s_timestamp;
                        pass_count_reg    <= '0;
                        shortest_reg      <= '1;
                        longest_reg       <= '0;
                        seen_reg          <= 1'b0;
                    end
                end
                lrwm_pkg::ST_UPDATE: begin
                    previous_time_reg <= now_reg;
                    // First pass of a window (or after count wrap) records no interval
                    if (pass_count_reg != 32'd0) begin
                        if (elapsed < shortest_reg) begin
                            shortest_reg <= elapsed;
                        end
                        if (elapsed > longest_reg) begin
                            longest_reg <= elapsed;
                        end
                        seen_reg <= 1'b1;
                    end
                    pass_count_reg <= pass_count_reg + 32'd1;
                end
                lrwm_pkg::ST_FINISH: begin
                    if (slot_free) begin
                        window_start_reg  <= now_reg;
                        previous_time_reg <= now_reg;
                        pass_count_reg    <= '0;
                        shortest_reg      <= '1;
                        longest_reg       <= '0;
                        seen_reg          <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath holding registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            now_reg <= s_timestamp;
        end
        if (state_reg == lrwm_pkg::ST_UPDATE) begin
            span_reg <= now_reg - window_start_reg;
        end
        if (state_reg == lrwm_pkg::ST_MUL) begin
            product_reg <= {30'd0, pass_count_reg} * {32'd0, clock_hz_reg};
        end
        if (div_rsp.done) begin
            case (state_reg)
                lrwm_pkg::ST_RATE_WAIT: rate_q_reg <= div_rsp.quotient;
                lrwm_pkg::ST_MIN_WAIT:  min_q_reg  <= seen_reg ? div_rsp.quotient[15:0]
                                                               : 16'd0;
                lrwm_pkg::ST_MAX_WAIT:  max_q_reg  <= div_rsp.quotient[15:0];
                default: ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == lrwm_pkg::ST_FINISH && slot_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == lrwm_pkg::ST_FINISH && slot_free) begin
            m_rate_reg <= rate_q_reg;
            m_min_reg  <= min_q_reg;
            m_max_reg  <= max_q_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_rate_hz         = m_rate_reg;
    assign m_min_interval_us = m_min_reg;
    assign m_max_interval_us = m_max_reg;

    // Divider results arrive only while the sequencer waits for them
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == lrwm_pkg::ST_RATE_WAIT ||
                          state_reg == lrwm_pkg::ST_MIN_WAIT ||
                          state_reg == lrwm_pkg::ST_MAX_WAIT))
        else $error("divider done outside a wait state");

    // A window with no recorded interval reports a zero minimum
    a_min_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lrwm_pkg::ST_FINISH && slot_free && !seen_reg)
            |=> (m_valid && m_min_interval_us == 16'd0))
        else $error("minimum interval not zero for window without intervals");

    // A restart empties the window
    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_kind == lrwm_pkg::KIND_RESTART)
            |=> (pass_count_reg == 32'd0 && !seen_reg && state_reg == lrwm_pkg::ST_IDLE))
        else $error("restart did not open an empty window");

endmodule

`default_nettype wire

// ===== tb/tb_loop_rate_window_meter_core.sv =====
// Self-checking testbench for loop_rate_window_meter_core: directed table, then random phases.
// Carries its own window predictor and checks every result; depends on lrwm_pkg and the core.
`default_nettype none

module tb_loop_rate_window_meter_core;

    localparam int PHASES          = 14;
    localparam int ITEMS_PER_PHASE = 124;
    localparam int DRAIN_CYCLES    = 100;
    localparam int HOLD_CYCLES     = 2000;
    localparam int CYCLE_LIMIT     = 1500000;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic [31:0] rate_hz;
        logic [15:0] min_us;
        logic [15:0] max_us;
    } window_t;

    typedef struct packed {
        bit          is_write;
        logic [1:0]  reg_idx;
        logic [31:0] wdata;
        logic        kind;
        logic [31:0] ts;
        bit          has_lit;
        window_t     lit;
    } plan_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_kind;
    logic [31:0] s_timestamp;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_rate_hz;
    logic [15:0] m_min_interval_us;
    logic [15:0] m_max_interval_us;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;

    // Predictor copy of the configuration
    logic [29:0] cfg_clock;
    logic [31:0] cfg_len;
    logic [9:0]  cfg_cpus;

    // Predictor copy of the window state
    logic [31:0] win_start;
    logic [31:0] last_pass_ts;
    logic [31:0] pass_cnt;
    logic [31:0] short_iv;
    logic [31:0] long_iv;
    bit          iv_seen;

    window_t     window_q[$];
    plan_row_t   plan[$];

    int  mismatch_count = 0;
    int  windows_checked = 0;
    int  items_sent = 0;
    int  reg_writes = 0;
    int  cycle_count = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;
    bit  hold_req = 1'b0;

    loop_rate_window_meter_core u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_timestamp       (s_timestamp),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_rate_hz         (m_rate_hz),
        .m_min_interval_us (m_min_interval_us),
        .m_max_interval_us (m_max_interval_us),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic void open_window(input logic [31:0] ts);
        win_start    = ts;
        last_pass_ts = ts;
        pass_cnt     = '0;
        short_iv     = '1;
        long_iv      = '0;
        iv_seen      = 1'b0;
    endfunction

    function automatic logic [15:0] cycles_to_us(input logic [31:0] cycles);
        logic [31:0] q;
        if (cfg_cpus == '0) begin
            return 16'hFFFF;
        end
        q = cycles / 32'(cfg_cpus);
        return (q > 32'hFFFF) ? 16'hFFFF : q[15:0];
    endfunction

    // Advance the window state by one item; closed is set when a window result is due
    function automatic void advance_meter(input logic kind, input logic [31:0] ts,
                                          output bit closed, output window_t res);
        logic [31:0] elapsed;
        logic [31:0] span;
        logic [63:0] quotient;
        closed = 1'b0;
        res    = '0;
        if (kind == lrwm_pkg::KIND_RESTART) begin
            open_window(ts);
            return;
        end
        elapsed      = ts - last_pass_ts;
        last_pass_ts = ts;
        // first pass of a window only marks the time
        if (pass_cnt != '0) begin
            if (elapsed < short_iv) short_iv = elapsed;
            if (elapsed > long_iv) long_iv = elapsed;
            iv_seen = 1'b1;
        end
        pass_cnt = pass_cnt + 32'd1;
        span = ts - win_start;
        if (span < cfg_len) begin
            return;
        end
        if (span == '0) begin
            quotient = 64'hFFFF_FFFF;
        end else begin
            quotient = (64'(pass_cnt) * 64'(cfg_clock)) / 64'(span);
            if (quotient > 64'hFFFF_FFFF) quotient = 64'hFFFF_FFFF;
        end
        closed         = 1'b1;
        res.rate_hz    = quotient[31:0];
        res.min_us     = iv_seen ? cycles_to_us(short_iv) : 16'd0;
        res.max_us     = cycles_to_us(long_iv);
        open_window(ts);
    endfunction

    function automatic plan_row_t wr_row(input logic [1:0] idx, input logic [31:0] val);
        plan_row_t r;
        r          = '0;
        r.is_write = 1'b1;
        r.reg_idx  = idx;
        r.wdata    = val;
        return r;
    endfunction

    function automatic plan_row_t in_row(input logic kind, input logic [31:0] ts);
        plan_row_t r;
        r      = '0;
        r.kind = kind;
        r.ts   = ts;
        return r;
    endfunction

    function automatic plan_row_t lit_row(input logic [31:0] ts, input logic [31:0] rate,
                                          input logic [15:0] mn, input logic [15:0] mx);
        plan_row_t r;
        r         = in_row(lrwm_pkg::KIND_ITERATION, ts);
        r.has_lit = 1'b1;
        r.lit     = '{rate_hz: rate, min_us: mn, max_us: mx};
        return r;
    endfunction

    // Hold the input low until every result is in and the block has had time to settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (window_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            lrwm_pkg::CFG_CLOCK_HZ:      cfg_clock = val[29:0];
            lrwm_pkg::CFG_WINDOW_LENGTH: cfg_len   = val;
            lrwm_pkg::CFG_CYCLES_PER_US: cfg_cpus  = val[9:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Offer one item, entered and left at a falling edge
    task automatic send_item(input logic kind, input logic [31:0] ts,
                             input bit has_lit, input window_t lit);
        bit      closed;
        window_t res;
        while (tx_idle_on && $urandom_range(99) < 22) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_kind      <= kind;
        s_timestamp <= ts;
        do @(posedge aclk); while (s_ready !== 1'b1);
        advance_meter(kind, ts, closed, res);
        if (has_lit) window_q.push_back(lit);
        else if (closed) window_q.push_back(res);
        items_sent++;
        @(negedge aclk);
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            m_ready <= !(rx_idle_on && $urandom_range(99) < 22);
        end
    end

    // Result checker
    always @(posedge aclk) begin
        window_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (window_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected window result at cycle %0d: rate %0d min %0d max %0d",
                             cycle_count, m_rate_hz, m_min_interval_us, m_max_interval_us);
            end else begin
                want = window_q.pop_front();
                windows_checked++;
                if (m_rate_hz !== want.rate_hz || m_min_interval_us !== want.min_us ||
                    m_max_interval_us !== want.max_us) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("cycle %0d exp/act rate %0d/%0d min %0d/%0d max %0d/%0d",
                                 cycle_count, want.rate_hz, m_rate_hz, want.min_us,
                                 m_min_interval_us, want.max_us, m_max_interval_us);
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, window_q.size());
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int          phase;
        int          n;
        int          pick;
        logic        kind;
        logic [31:0] ts;
        logic [31:0] clock_now;
        logic [31:0] step_max;
        logic [31:0] len;
        logic [29:0] clk;
        logic [9:0]  cpus;
        window_t     nolit;

        s_valid     = 1'b0;
        s_kind      = lrwm_pkg::KIND_ITERATION;
        s_timestamp = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = lrwm_pkg::CFG_CLOCK_HZ;
        cfg_wdata   = '0;
        aresetn     = 1'b0;
        nolit       = '0;
        cfg_clock   = lrwm_pkg::CLOCK_HZ_RESET;
        cfg_len     = lrwm_pkg::WINDOW_LENGTH_RESET;
        cfg_cpus    = lrwm_pkg::CYCLES_PER_US_RESET;
        open_window('0);

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed table: reset defaults, zero span, zero divisor, rate overflow, wrap
        plan.push_back(in_row(lrwm_pkg::KIND_ITERATION, 32'd0));
        plan.push_back(lit_row(32'd125000000, 32'd2, 16'hFFFF, 16'hFFFF));
        plan.push_back(wr_row(lrwm_pkg::CFG_WINDOW_LENGTH, 32'd0));
        plan.push_back(in_row(lrwm_pkg::KIND_RESTART, 32'd100));
        plan.push_back(lit_row(32'd100, 32'hFFFF_FFFF, 16'd0, 16'd0));
        plan.push_back(wr_row(lrwm_pkg::CFG_CYCLES_PER_US, 32'd0));
        plan.push_back(lit_row(32'd105, 32'd25000000, 16'd0, 16'hFFFF));
        plan.push_back(wr_row(lrwm_pkg::CFG_WINDOW_LENGTH, 32'd1));
        plan.push_back(wr_row(lrwm_pkg::CFG_CLOCK_HZ, 32'h3FFF_FFFF));
        plan.push_back(in_row(lrwm_pkg::KIND_RESTART, 32'd200));
        plan.push_back(in_row(lrwm_pkg::KIND_ITERATION, 32'd200));
        plan.push_back(in_row(lrwm_pkg::KIND_ITERATION, 32'd200));
        plan.push_back(in_row(lrwm_pkg::KIND_ITERATION, 32'd200));
        plan.push_back(in_row(lrwm_pkg::KIND_ITERATION, 32'd200));
        plan.push_back(lit_row(32'd201, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
        plan.push_back(wr_row(lrwm_pkg::CFG_CYCLES_PER_US, 32'd1000));
        plan.push_back(wr_row(lrwm_pkg::CFG_CLOCK_HZ, 32'd1000000));
        plan.push_back(wr_row(lrwm_pkg::CFG_WINDOW_LENGTH, 32'hFFFF_FFFF));
        plan.push_back(in_row(lrwm_pkg::KIND_RESTART, 32'h8000_0000));
        plan.push_back(in_row(lrwm_pkg::KIND_ITERATION, 32'h8000_03E8));
        plan.push_back(lit_row(32'h7FFF_FFFF, 32'd0, 16'hFFFF, 16'hFFFF));
        plan.push_back(wr_row(lrwm_pkg::CFG_CYCLES_PER_US, 32'd7));
        plan.push_back(wr_row(lrwm_pkg::CFG_WINDOW_LENGTH, 32'd3000));
        plan.push_back(wr_row(lrwm_pkg::CFG_CLOCK_HZ, 32'd1000000000));
        plan.push_back(in_row(lrwm_pkg::KIND_ITERATION, 32'h8000_01F3));
        plan.push_back(in_row(lrwm_pkg::KIND_ITERATION, 32'h8000_04AF));
        plan.push_back(in_row(lrwm_pkg::KIND_ITERATION, 32'h8000_04E1));
        plan.push_back(in_row(lrwm_pkg::KIND_ITERATION, 32'h8000_0C1B));
        plan.push_back(in_row(lrwm_pkg::KIND_RESTART, 32'hFFFF_FFFF));
        plan.push_back(in_row(lrwm_pkg::KIND_ITERATION, 32'd0));
        plan.push_back(in_row(lrwm_pkg::KIND_ITERATION, 32'd3000));

        foreach (plan[i]) begin
            if (plan[i].is_write) write_reg(plan[i].reg_idx, plan[i].wdata);
            else send_item(plan[i].kind, plan[i].ts, plan[i].has_lit, plan[i].lit);
        end

        clock_now = $urandom();
        for (phase = 0; phase < PHASES; phase++) begin
            case ($urandom_range(5))
                0:       clk = 30'd1000000;
                1:       clk = 30'd1000000000;
                2:       clk = '1;
                3:       clk = '0;
                default: clk = 30'($urandom_range(1000000000, 1000000));
            endcase
            case ($urandom_range(5))
                0:       cpus = 10'd1;
                1:       cpus = 10'd1000;
                2:       cpus = '0;
                3:       cpus = '1;
                default: cpus = 10'($urandom_range(1000, 1));
            endcase
            if (phase == 0) len = '0;
            else if (phase == 2) len = '1;
            else if (phase == 5) len = 32'd1;
            else if ($urandom_range(3) == 0) len = $urandom_range(64, 1);
            else len = $urandom_range(200000, 1);

            write_reg(lrwm_pkg::CFG_CLOCK_HZ, {2'b00, clk});
            write_reg(lrwm_pkg::CFG_CYCLES_PER_US, {22'd0, cpus});
            write_reg(lrwm_pkg::CFG_WINDOW_LENGTH, len);

            if (len == '0) step_max = 32'd500;
            else if (len == '1) step_max = 32'h4000_0000;
            else step_max = len / 2 + 1;

            // phase 0 closes a window on every pass, so a long hold-off backs up the input
            if (phase == 0) hold_req = 1'b1;
            tx_idle_on = (phase != 1);
            rx_idle_on = (phase != 1);

            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(99);
                if (pick < 4) begin
                    kind      = lrwm_pkg::KIND_RESTART;
                    clock_now = clock_now + $urandom_range(step_max);
                    ts        = clock_now;
                end else if (pick < 8) begin
                    kind      = 1'($urandom_range(1));
                    ts        = $urandom();
                    clock_now = ts;
                end else begin
                    kind = lrwm_pkg::KIND_ITERATION;
                    if (pick >= 14) clock_now = clock_now + $urandom_range(step_max);
                    ts = clock_now;
                end
                send_item(kind, ts, 1'b0, nolit);
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;

        wait_idle();
        $display("run covered %0d input items across %0d register writes, %0d windows checked",
                 items_sent, reg_writes, windows_checked);
        $display("%0d mismatches, %0d results still outstanding",
                 mismatch_count, window_q.size());
        if (mismatch_count == 0 && window_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
